// ===== hdl/etqs_pkg.sv =====
// package: types, constants and note tables for the tone sequencer
`default_nettype none
package etqs_pkg;

   localparam int RING_SLOTS = 4;
   localparam int RING_PTR_W = $clog2(RING_SLOTS);
   localparam int TICK_VARIANTS = 5;
   localparam int VARIANT_W = 3;
   localparam int MAX_STEPS = 16;
   localparam int STEP_W = $clog2(MAX_STEPS) + 1;
   localparam int NOTE_ROM_DEPTH = 128;
   localparam int ROM_LEN = 127;
   localparam int BASE_W = 7;
   localparam int IDX_W = 8;
   localparam int CODE_W = 5;
   localparam int CODE_COUNT = 25;

   localparam logic [CODE_W-1:0] CODE_NONE = 5'd0;
   localparam logic [CODE_W-1:0] CODE_TERM_TICK = 5'd14;
   localparam logic [CODE_W-1:0] CODE_MAX = 5'd24;
   localparam logic [7:0] NO_SEQ = 8'd255;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_EVENT = 1'b1;

   typedef struct packed {
      logic [15:0] freq;
      logic [15:0] dur;
      logic [15:0] pause;
   } note_type;

   typedef struct packed {
      logic        tone_start;
      logic [15:0] tone_freq;
      logic [15:0] tone_ms;
      logic        tone_stop;
      logic        events_waiting;
      logic        playing;
   } result_type;

   localparam note_type NOTE_ROM [ROM_LEN] = '{
      '{1050, 6, 0}, '{0, 0, 0},
      '{900, 7, 0}, '{0, 0, 0},
      '{260, 12, 2}, '{540, 3, 0}, '{0, 0, 0},
      '{240, 13, 2}, '{500, 3, 0}, '{0, 0, 0},
      '{280, 11, 2}, '{600, 3, 0}, '{0, 0, 0},
      '{220, 14, 2}, '{460, 3, 2}, '{140, 10, 0}, '{0, 0, 0},
      '{300, 10, 2}, '{620, 3, 2}, '{160, 12, 0}, '{0, 0, 0},
      '{820, 5, 0}, '{0, 0, 0},
      '{1000, 6, 0}, '{0, 0, 0},
      '{400, 70, 0}, '{0, 0, 0},
      '{1000, 50, 15}, '{1300, 50, 0}, '{0, 0, 0},
      '{800, 60, 15}, '{1000, 60, 15}, '{1200, 80, 15}, '{1000, 100, 0}, '{0, 0, 0},
      '{600, 80, 25}, '{900, 80, 25}, '{1200, 100, 0}, '{0, 0, 0},
      '{500, 80, 20}, '{700, 80, 20}, '{1000, 80, 20}, '{1200, 120, 0}, '{0, 0, 0},
      '{700, 50, 15}, '{900, 50, 15}, '{1100, 50, 15}, '{1400, 100, 0}, '{0, 0, 0},
      '{500, 60, 15}, '{700, 60, 15}, '{900, 60, 15}, '{1100, 80, 20}, '{1400, 150, 0},
      '{0, 0, 0},
      '{900, 80, 40}, '{1100, 80, 0}, '{0, 0, 0},
      '{800, 70, 20}, '{1000, 70, 20}, '{1200, 100, 0}, '{0, 0, 0},
      '{240, 50, 20}, '{180, 60, 0}, '{0, 0, 0},
      '{140, 650, 140}, '{600, 12, 30}, '{700, 12, 30}, '{520, 12, 60}, '{120, 180, 80},
      '{800, 12, 30}, '{640, 12, 30}, '{500, 12, 60}, '{900, 10, 30}, '{700, 10, 30},
      '{850, 10, 60}, '{170, 230, 70}, '{210, 320, 90}, '{240, 360, 0}, '{0, 0, 0},
      '{160, 480, 140}, '{540, 12, 40}, '{660, 12, 40}, '{560, 12, 80}, '{120, 160, 70},
      '{820, 10, 40}, '{700, 10, 60}, '{190, 210, 70}, '{220, 220, 70}, '{180, 240, 0},
      '{0, 0, 0},
      '{500, 35, 0}, '{800, 35, 0}, '{500, 35, 0}, '{800, 35, 0}, '{0, 0, 0},
      '{800, 80, 25}, '{500, 120, 0}, '{0, 0, 0},
      '{900, 40, 0}, '{0, 0, 0},
      '{700, 40, 15}, '{1000, 50, 0}, '{0, 0, 0},
      '{700, 60, 20}, '{900, 60, 20}, '{1100, 80, 0}, '{0, 0, 0},
      '{800, 70, 20}, '{1000, 70, 20}, '{1200, 70, 20}, '{1500, 100, 15}, '{1200, 80, 0},
      '{0, 0, 0},
      '{43, 200, 20}, '{172, 80, 0}, '{178, 80, 0}, '{172, 80, 0}, '{178, 80, 0},
      '{247, 60, 0},
      '{172, 80, 0}, '{178, 80, 0}, '{311, 60, 0}, '{174, 400, 0}, '{87, 400, 0},
      '{43, 800, 0},
      '{0, 0, 0}
   };

   localparam logic [7:0] CODE_BASE [CODE_COUNT] = '{
      8'd255, 8'd25, 8'd30, 8'd27, 8'd21, 8'd35, 8'd39, 8'd44, 8'd49, 8'd55, 8'd58,
      8'd62, 8'd0, 8'd2, 8'd255, 8'd65, 8'd80, 8'd91, 8'd23, 8'd96, 8'd99, 8'd101,
      8'd104, 8'd108, 8'd114
   };

   localparam logic [BASE_W-1:0] VARIANT_BASE [TICK_VARIANTS] = '{
      7'd4, 7'd7, 7'd10, 7'd13, 7'd17
   };

   function automatic note_type fetch_note(input logic [BASE_W-1:0] base,
                                           input logic [STEP_W-1:0] step);
      logic [IDX_W-1:0] idx;
      note_type n;
      idx = IDX_W'(base) + IDX_W'(step);
      n = '0;
      if (step < STEP_W'(MAX_STEPS) && idx < IDX_W'(NOTE_ROM_DEPTH)
          && idx < IDX_W'(ROM_LEN)) begin
         n = NOTE_ROM[idx[BASE_W-1:0]];
      end
      return n;
   endfunction

   function automatic logic is_priority(input logic [CODE_W-1:0] c);
      return c == 5'd2 || c == 5'd3 || c == 5'd5 || c == 5'd6 || c == 5'd7
             || c == 5'd8 || c == 5'd23;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/etqs_ifc.sv =====
// interfaces: request, response and control-write channels
`default_nettype none
interface etqs_req_ifc;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [4:0] event_code;
   modport source (output valid, mode, event_code, input ready);
   modport sink (input valid, mode, event_code, output ready);
endinterface

interface etqs_rsp_ifc;
   logic        valid;
   logic        ready;
   logic        tone_start;
   logic [15:0] tone_freq;
   logic [15:0] tone_ms;
   logic        tone_stop;
   logic        events_waiting;
   logic        playing;
   modport source (output valid, tone_start, tone_freq, tone_ms, tone_stop,
                   events_waiting, playing, input ready);
   modport sink (input valid, tone_start, tone_freq, tone_ms, tone_stop,
                 events_waiting, playing, output ready);
endinterface

interface etqs_csr_ifc;
   logic valid;
   logic ready;
   logic sound_enabled;
   modport source (output valid, sound_enabled, input ready);
   modport sink (input valid, sound_enabled, output ready);
endinterface
`default_nettype wire

// ===== hdl/etqs_core.sv =====
// sequencer state and single-pass step logic
`default_nettype none
module etqs_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step_en,
   input  wire logic                     mode,
   input  wire logic [etqs_pkg::CODE_W-1:0] code,
   input  wire logic                     enabled,
   output etqs_pkg::result_type          result
);
   import etqs_pkg::*;

   logic [CODE_W-1:0]     ring_ff [RING_SLOTS];
   logic [RING_PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic                  active_ff, active_in;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [15:0]           el_ff, el_in;
   logic                  ph_ff, ph_in;
   logic [VARIANT_W-1:0]  tv_ff, tv_in;
   logic                  ring_we;
   logic [CODE_W-1:0]     ev;
   logic [7:0]            new_base;
   logic [RING_PTR_W-1:0] wp_t, rp_t;
   logic [STEP_W-1:0]     step2;
   note_type              e, e2;

   always_comb begin
      result = '0;
      wp_in = wp_ff; rp_in = rp_ff; active_in = active_ff; base_in = base_ff;
      step_in = step_ff; el_in = el_ff; ph_in = ph_ff; tv_in = tv_ff;
      ring_we = 1'b0; wp_t = wp_ff; rp_t = rp_ff;
      ev = ring_ff[rp_ff]; new_base = NO_SEQ; step2 = step_ff;
      e = '0; e2 = '0;
      if (mode == MODE_EVENT) begin
         if (enabled && code != CODE_NONE) begin
            if (is_priority(code) && active_ff) begin
               result.tone_stop = 1'b1;
               active_in = 1'b0;
               step_in = '0;
               wp_t = '0;
               rp_t = '0;
            end
            // drop oldest when the write would meet the read pointer
            if (RING_PTR_W'(wp_t + 1'b1) == rp_t) begin
               rp_t = RING_PTR_W'(rp_t + 1'b1);
            end
            ring_we = 1'b1;
            wp_in = RING_PTR_W'(wp_t + 1'b1);
            rp_in = rp_t;
         end
         result.playing = active_in;
      end else if (!enabled) begin
         wp_in = rp_ff;
         active_in = 1'b0;
      end else begin
         if (rp_ff != wp_ff && !active_ff) begin
            rp_in = RING_PTR_W'(rp_ff + 1'b1);
            if (ev == CODE_TERM_TICK) begin
               new_base = 8'(VARIANT_BASE[tv_ff]);
               tv_in = (tv_ff == VARIANT_W'(TICK_VARIANTS - 1)) ? '0
                       : VARIANT_W'(tv_ff + 1'b1);
            end else if (ev <= CODE_MAX) begin
               new_base = CODE_BASE[ev];
            end
            if (new_base != NO_SEQ) begin
               base_in = new_base[BASE_W-1:0];
               step_in = '0;
               ph_in = 1'b1;
               el_in = '0;
               active_in = 1'b1;
               e = fetch_note(new_base[BASE_W-1:0], '0);
               if (e.freq != 0 && e.dur != 0) begin
                  result.tone_start = 1'b1;
                  result.tone_freq = e.freq;
                  result.tone_ms = e.dur;
               end
               if (e.dur == 0) begin
                  active_in = 1'b0;
               end
            end
         end else if (active_ff) begin
            el_in = (el_ff == 16'hffff) ? el_ff : 16'(el_ff + 1'b1);
            e = fetch_note(base_ff, step_ff);
            step2 = (step_ff < STEP_W'(MAX_STEPS)) ? STEP_W'(step_ff + 1'b1) : step_ff;
            e2 = fetch_note(base_ff, step2);
            if (e.dur == 0) begin
               active_in = 1'b0;
               step_in = '0;
            end else if ((ph_ff && el_in >= e.dur && e.pause == 0)
                         || (!ph_ff && el_in >= e.pause)) begin
               // next entry of the sequence starts
               step_in = step2;
               ph_in = 1'b1;
               el_in = '0;
               if (e2.freq != 0 && e2.dur != 0) begin
                  result.tone_start = 1'b1;
                  result.tone_freq = e2.freq;
                  result.tone_ms = e2.dur;
               end
            end else if (ph_ff && el_in >= e.dur) begin
               el_in = '0;
               ph_in = 1'b0;
            end
         end
         result.events_waiting = rp_in != wp_ff;
         result.playing = active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; active_ff <= 1'b0; base_ff <= '0;
         step_ff <= '0; el_ff <= '0; ph_ff <= 1'b0; tv_ff <= '0;
      end else if (step_en) begin
         wp_ff <= wp_in; rp_ff <= rp_in; active_ff <= active_in; base_ff <= base_in;
         step_ff <= step_in; el_ff <= el_in; ph_ff <= ph_in; tv_ff <= tv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && ring_we) begin
         ring_ff[wp_t] <= code;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/event_queued_tone_sequencer_unit.sv =====
// top level: input register, step logic and result register
`default_nettype none
// Tone sequencer: each request transfer is either a 1 ms tick (mode 0) or a sound
// event (mode 1) and yields exactly one response transfer. Events wait in a
// four-slot ring that drops its oldest entry and so holds at most three; a priority
// event during playback stops the tone and clears the ring. On a tick with nothing
// playing the oldest event starts its note sequence, reported through tone_start,
// tone_freq and tone_ms. Throughput is one item per clock while the response is not
// stalled: a request is captured in the input register, the step logic (ring update
// plus note table lookup) runs combinationally on it and the result lands in the
// response register; a stalled response only holds the pipe. Clearing sound_enabled
// drops the queue and the sequence on the next tick.
module event_queued_tone_sequencer_unit (
   input wire logic   clock,
   input wire logic   reset,
   etqs_req_ifc.sink  req_ch,
   etqs_rsp_ifc.source rsp_ch,
   etqs_csr_ifc.sink  csr_ch
);
   import etqs_pkg::*;

   logic              in_valid_ff;
   logic              in_mode_ff;
   logic [CODE_W-1:0] in_code_ff;
   logic              out_valid_ff;
   result_type        out_ff;
   result_type        step_result;
   logic              enabled_ff;
   logic              fire;

   // a step runs when an item waits and the result register is free or draining
   assign fire = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || fire;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
      end else if (csr_ch.valid) begin
         enabled_ff <= csr_ch.sound_enabled;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_mode_ff <= req_ch.mode;
         in_code_ff <= req_ch.event_code;
      end
   end

   etqs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (fire),
      .mode    (in_mode_ff),
      .code    (in_code_ff),
      .enabled (enabled_ff),
      .result  (step_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= step_result;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.tone_start     = out_ff.tone_start;
   assign rsp_ch.tone_freq      = out_ff.tone_freq;
   assign rsp_ch.tone_ms        = out_ff.tone_ms;
   assign rsp_ch.tone_stop      = out_ff.tone_stop;
   assign rsp_ch.events_waiting = out_ff.events_waiting;
   assign rsp_ch.playing        = out_ff.playing;

   // a cut-off leaves nothing playing
   a_stop_not_playing: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.tone_stop) |-> !out_ff.playing)
      else $error("tone stop reported while playing");

   // no tone data without a tone start
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.tone_start) |-> (out_ff.tone_freq == 16'd0
                                               && out_ff.tone_ms == 16'd0))
      else $error("tone fields set without tone start");

   // every step loads a valid result into the result register
   a_fire_needs_item: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("step did not produce a result");
endmodule
`default_nettype wire
